/* sv/som_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_pkg
// Shared types and constants for the self-organizing map training block.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int COMP_W = 16;
  localparam int DIST_W = 34;
  localparam int STEP_W = 16;
  localparam int RATE_W = 17;

  localparam logic [1:0] REQ_TRAIN    = 2'd0;
  localparam logic [1:0] REQ_LOAD     = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_RATE   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the request payload
    logic load_wr;    // write the three weights of a load request
    logic rd_issue;   // issue a weight read for node rd_node
    logic dist_acc;   // accumulate the distance of the node read through the memory and square registers
    logic dist_first; // that node is the first one of the scan
    logic div_start;  // start the rate and radius dividers
    logic upd_wr;     // write back the updated weights of the node read earlier
    logic step_inc;   // advance the step count
  } som_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } som_sts_t;

endpackage

/* sv/som_train_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_train_step
// Kohonen self-organizing map: load, classify and train requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time; a train request runs the winner scan, then waits
// for the rate and radius dividers, then sweeps the update over every node.
// The winner scan reads one node per cycle from the single read port of the
// weight RAM, which sets the rate.
// Reset clears the step count and the registers to radius 3 and rate scale
// 20; the node weights are undefined until loaded.
module som_train_step #(
  parameter int GRID_W = 5,
  parameter int GRID_H = 5
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: node_index[4:0], comp_0[20:5], comp_1[36:21], comp_2[52:37].
  input  logic [55:0] s_axis_tdata,
  // tuser: req_type[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: winner[4:0], min_distance[38:5], step_count[54:39].
  output logic [55:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import som_pkg::*;

  localparam int NW = $clog2(GRID_W * GRID_H);

  som_cmd_t      cmd;
  som_sts_t      sts;
  logic [NW-1:0] rd_node, acc_node, wr_node, best_node;
  logic [33:0]   best_dist;
  logic [15:0]   steps;
  logic [2:0]    radius, radius_base;
  logic [7:0]    rate_scale;
  logic          is_load;
  logic [4:0]    load_node;

  // Registers are written in the access phase of a write request.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_base <= 3'd3;
      rate_scale  <= 8'd20;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_RADIUS) begin
        radius_base <= pwdata[2:0];
      end else begin
        rate_scale <= pwdata[7:0];
      end
    end
  end
  assign prdata = (paddr[2] == REG_RATE) ? {24'd0, rate_scale} : {29'd0, radius_base};

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      load_node <= s_axis_tdata[4:0];
    end
  end

  som_ctrl #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts),
    .rd_node   (rd_node),
    .acc_node  (acc_node),
    .wr_node   (wr_node),
    .best_node (best_node),
    .radius    (radius),
    .is_load   (is_load)
  );

  som_datapath #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .rd_node     (rd_node),
    .acc_node    (acc_node),
    .wr_node     (wr_node),
    .in_node     (s_axis_tdata[4:0]),
    .in_c0       (s_axis_tdata[20:5]),
    .in_c1       (s_axis_tdata[36:21]),
    .in_c2       (s_axis_tdata[52:37]),
    .radius_base (radius_base),
    .rate_scale  (rate_scale),
    .best_node   (best_node),
    .best_dist   (best_dist),
    .steps       (steps),
    .radius      (radius)
  );

  // A load echoes its index with zero distance.
  assign m_axis_tdata = {1'b0,
                         steps,
                         is_load ? 34'd0 : best_dist,
                         is_load ? load_node : 5'(best_node)};
endmodule

/* sv/som_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module som_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/som_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module som_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* sv/som_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_datapath
// Weight memory, distance pipeline, winner tracking, rate and update math.
// ----------------------------------------------------------------------------
module som_datapath #(
  parameter int GRID_W = 5,
  parameter int GRID_H = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  som_pkg::som_cmd_t       cmd,
  output som_pkg::som_sts_t       sts,
  input  logic [$clog2(GRID_W*GRID_H)-1:0] rd_node,
  input  logic [$clog2(GRID_W*GRID_H)-1:0] acc_node,
  input  logic [$clog2(GRID_W*GRID_H)-1:0] wr_node,
  input  logic [4:0]              in_node,
  input  logic [15:0]             in_c0,
  input  logic [15:0]             in_c1,
  input  logic [15:0]             in_c2,
  input  logic [2:0]              radius_base,
  input  logic [7:0]              rate_scale,
  output logic [$clog2(GRID_W*GRID_H)-1:0] best_node,
  output logic [33:0]             best_dist,
  output logic [15:0]             steps,
  output logic [2:0]              radius
);
  import som_pkg::*;

  localparam int NODES = GRID_W * GRID_H;
  localparam int NW    = $clog2(NODES);

  logic signed [COMP_W-1:0] s [3];
  logic [4:0]               load_node;
  logic [47:0]              rdata;
  logic signed [COMP_W-1:0] w [3];
  logic [33:0]              sq [3];
  logic [33:0]              dsum;
  logic                     we;
  logic [NW-1:0]            waddr;
  logic [47:0]              wdata, upd_data;
  logic [23:0]              rate_q, rad_q;
  logic [16:0]              rate;
  logic                     rbusy, dbusy;

  assign w[0] = rdata[15:0];
  assign w[1] = rdata[31:16];
  assign w[2] = rdata[47:32];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s[0]      <= in_c0;
      s[1]      <= in_c1;
      s[2]      <= in_c2;
      load_node <= in_node;
    end
  end

  // Distance: squares registered, then summed and compared.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [16:0] d;
      d = 17'(s[k]) - 17'(w[k]);
      sq[k] <= 34'(d * d);
    end
  end

  assign dsum = sq[0] + sq[1] + sq[2];

  always_ff @(posedge clk) begin
    if (cmd.dist_acc) begin
      if (cmd.dist_first || dsum < best_dist) begin
        best_dist <= dsum;
        best_node <= acc_node;
      end
    end
  end

  // Update: new = w + floor((diff * rate + 2^15) / 2^16).
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [16:0] d;
      logic signed [34:0] p;
      d = 17'(s[k]) - 17'(w[k]);
      p = 35'(d) * 35'($signed({1'b0, rate})) + 35'sd32768;
      upd_data[k*16 +: 16] = 16'(w[k] + 16'(p >>> 16));
    end
  end

  assign we    = cmd.load_wr ? (int'(load_node) < NODES) : cmd.upd_wr;
  assign waddr = cmd.load_wr ? NW'(load_node) : wr_node;
  assign wdata = cmd.load_wr ? {s[2], s[1], s[0]} : upd_data;

  som_ram #(.WIDTH(48), .DEPTH(NODES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_node),
    .rdata (rdata)
  );

  som_div #(.NUM_W(24), .DEN_W(17)) u_rate_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({rate_scale, 16'd0}),
    .den   (17'(rate_scale) + 17'(steps)),
    .busy  (rbusy),
    .quo   (rate_q)
  );

  som_div #(.NUM_W(24), .DEN_W(17)) u_rad_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (24'(radius_base)),
    .den   (17'(steps) + 17'd1),
    .busy  (dbusy),
    .quo   (rad_q)
  );

  // A zero denominator leaves an all-ones quotient; the rate must be zero then.
  assign rate   = (rate_scale == 8'd0) ? 17'd0 : rate_q[16:0];
  assign radius = rad_q[2:0];
  assign sts.div_busy = rbusy | dbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.step_inc && steps != 16'hFFFF) begin
      steps <= steps + 1'b1;
    end
  end
endmodule

/* sv/som_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_ctrl
// Request sequencer: load write, winner scan, neighbor update sweep and result hand-off.
// ----------------------------------------------------------------------------
module som_ctrl #(
  parameter int GRID_W = 5,
  parameter int GRID_H = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output som_pkg::som_cmd_t       cmd,
  input  som_pkg::som_sts_t       sts,
  output logic [$clog2(GRID_W*GRID_H)-1:0] rd_node,
  output logic [$clog2(GRID_W*GRID_H)-1:0] acc_node,
  output logic [$clog2(GRID_W*GRID_H)-1:0] wr_node,
  input  logic [$clog2(GRID_W*GRID_H)-1:0] best_node,
  input  logic [2:0]              radius,
  output logic                    is_load
);
  import som_pkg::*;

  localparam int NODES = GRID_W * GRID_H;
  localparam int NW    = $clog2(NODES);
  localparam int XW    = $clog2(GRID_W + 1);
  localparam int YW    = $clog2(GRID_H + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_DIV, S_UPD, S_DONE
  } state_t;

  state_t        state;
  logic [1:0]    req;
  logic [NW:0]   cnt;
  logic [NW-1:0] p1, p2;
  logic          v1, v2;
  logic [XW-1:0] ux, wx;
  logic [YW-1:0] uy, wy;
  logic          hit;

  // Winner coordinates by walking the index, only a few dozen nodes.
  always_comb begin
    wx = '0;
    wy = '0;
    for (int i = 0; i < NODES; i++) begin
      if (NW'(i) == best_node) begin
        wx = XW'(i % GRID_W);
        wy = YW'(i / GRID_W);
      end
    end
  end

  always_comb begin
    logic signed [5:0] dx, dy;
    dx  = 6'($signed({1'b0, ux})) - 6'($signed({1'b0, wx}));
    dy  = 6'($signed({1'b0, uy})) - 6'($signed({1'b0, wy}));
    hit = (11'(dx * dx) + 11'(dy * dy)) <= 11'(radius * radius);
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc_node = p2;
  // The update is written back while the read data of that node is on the
  // memory output, in the cycle after the read.
  assign wr_node  = p1;

  always_comb begin
    cmd = '0;
    cmd.capture    = in_valid && in_ready;
    cmd.load_wr    = (state == S_LOAD);
    cmd.rd_issue   = (state == S_SCAN || state == S_UPD) && cnt < (NW+1)'(NODES);
    cmd.dist_acc   = (state == S_SCAN) && v2;
    cmd.dist_first = (p2 == '0);
    cmd.div_start  = (state == S_SCAN) && v2 && p2 == NW'(NODES - 1) && req == REQ_TRAIN;
    cmd.upd_wr     = (state == S_UPD) && v1;
    cmd.step_inc   = (state == S_UPD) && cnt == (NW+1)'(NODES) && !v1 && !v2;
  end

  assign rd_node = NW'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      cnt       <= '0;
      is_load   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Two-stage read pipeline: memory register, then square register.
      v1 <= cmd.rd_issue && (state == S_SCAN || hit);
      p1 <= rd_node;
      v2 <= v1;
      p2 <= p1;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req     <= in_req;
            is_load <= (in_req == REQ_LOAD);
            cnt     <= '0;
            state   <= (in_req == REQ_LOAD) ? S_LOAD : S_SCAN;
          end
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_SCAN: begin
          if (cnt < (NW+1)'(NODES)) begin
            cnt <= cnt + 1'b1;
          end
          if (v2 && p2 == NW'(NODES - 1)) begin
            cnt <= '0;
            if (req == REQ_TRAIN) begin
              state <= S_DIV;
            end else begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (!sts.div_busy) begin
            state <= S_UPD;
            ux    <= '0;
            uy    <= '0;
          end
        end
        S_UPD: begin
          if (cnt < (NW+1)'(NODES)) begin
            cnt <= cnt + 1'b1;
            if (ux == XW'(GRID_W - 1)) begin
              ux <= '0;
              uy <= uy + 1'b1;
            end else begin
              ux <= ux + 1'b1;
            end
          end else if (!v1 && !v2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The update sweep only writes nodes it has read.
  assert property (@(posedge clk) disable iff (rst) cmd.upd_wr |-> $past(cmd.rd_issue));
  // A result is raised only when no request is being worked on.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> state == S_IDLE)
    else $error("result raised mid-request");
  // Dividers are started only out of the scan, and the divide wait follows.
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> state == S_DIV)
    else $error("divider start without divide wait");
endmodule
